// ===== rtl/gbte_pkg.sv =====
// Shared types and codes for the gap buffer text editor.
package gbte_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_MOVE   = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_FULL       = 3'd1,
    ST_BAD_MOVE   = 3'd2,
    ST_NO_DELETE  = 3'd3,
    ST_READ_RANGE = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_MOVE   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_RDWAIT = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

endpackage

// ===== rtl/gbte_ram.sv =====
// Byte store with one write port and one registered read port.
module gbte_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/gap_buffer_text_editor.sv =====
// Top level of the gap buffer text editor: control, gap walker and result register.
//
// Usage. Commands arrive on the request channel (req_valid, req_stall, cmd, char_in,
// move_amount, read_pos); one transfer carries one command. Each command yields exactly
// one result on the response channel (rsp_valid, rsp_stall, status, cursor_pos,
// text_length, char_out), in command order.
// Operation. The block works on one command at a time. A move command or a rejected
// command goes from S_IDLE to S_DONE and then to the response register; a read passes
// through S_RDWAIT, and an insert or delete with the gap already at the cursor through
// S_EXEC, before S_DONE. When the gap has to be brought to the cursor, S_MOVE walks one
// byte per cycle through the byte store before S_EXEC.
// The byte store's one read port and one write port set that walking rate.
// Reset. The text is empty, the cursor is at zero and no result is pending. The byte
// store itself is not cleared; only bytes written by inserts are ever read back.
// Back pressure. A finished result sits in the response register until it is taken;
// while rsp_stall holds it there, the next finished result waits in the control and
// the request channel stalls.
module gap_buffer_text_editor
  import gbte_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         char_in,
  input  logic signed [11:0] move_amount,
  input  logic [9:0]         read_pos,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic [2:0]         status,
  output logic [10:0]        cursor_pos,
  output logic [10:0]        text_length,
  output logic [7:0]         char_out
);

  // Address width of the byte store, width of positions that can reach CAPACITY,
  // and a width wide enough for the signed cursor arithmetic.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int XW = PW + 13;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  // Control state.
  state_t        state, state_next;
  logic [PW-1:0] gap_first, gap_first_next;
  logic [PW-1:0] gap_end, gap_end_next;
  logic [PW-1:0] cursor, cursor_next;
  logic          pend, pend_next;
  logic          rsp_valid_next;

  // Payload registers.
  logic [AW-1:0] pend_addr, pend_addr_next;
  cmd_t          cmd_q, cmd_q_next;
  logic [7:0]    char_q, char_q_next;
  status_t       res_status, res_status_next;
  logic [7:0]    res_char, res_char_next;
  status_t       rsp_status, rsp_status_next;
  logic [10:0]   rsp_cursor, rsp_cursor_next;
  logic [10:0]   rsp_length, rsp_length_next;
  logic [7:0]    rsp_char, rsp_char_next;

  // Byte store ports.
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  // Derived quantities of the current state.
  logic [PW-1:0] gap_width, text_len;
  logic [PW-1:0] gf_inc, gf_dec, ge_inc, ge_dec;
  logic          move_left, gap_at_cursor, rsp_free, req_xfer;
  logic [XW-1:0] rpos_x, len_x, target, phys;
  logic          target_bad, read_bad;
  logic [PW+10:0] cursor_w, length_w;

  assign gap_width     = gap_end - gap_first;
  assign text_len      = CAP_P - gap_width;
  assign gf_inc        = gap_first + 1'b1;
  assign gf_dec        = gap_first - 1'b1;
  assign ge_inc        = gap_end + 1'b1;
  assign ge_dec        = gap_end - 1'b1;
  assign move_left     = cursor < gap_first;
  assign gap_at_cursor = gap_first == cursor;
  assign rsp_free      = !rsp_valid || !rsp_stall;

  assign req_stall = state != S_IDLE;
  assign req_xfer  = req_valid && !req_stall;

  // Move target and read position, worked in a width that cannot overflow.
  assign rpos_x     = XW'(read_pos);
  assign len_x      = XW'(text_len);
  assign target     = XW'(cursor) + XW'(move_amount);
  assign target_bad = target[XW-1] || (target > len_x);
  assign read_bad   = rpos_x >= len_x;
  assign phys       = (rpos_x < XW'(gap_first)) ? rpos_x : rpos_x + XW'(gap_width);

  // Reported positions are the low 11 bits of the internal ones.
  assign cursor_w = {11'b0, cursor};
  assign length_w = {11'b0, text_len};

  always_comb begin
    state_next      = state;
    gap_first_next  = gap_first;
    gap_end_next    = gap_end;
    cursor_next     = cursor;
    pend_next       = 1'b0;
    pend_addr_next  = pend_addr;
    cmd_q_next      = cmd_q;
    char_q_next     = char_q;
    res_status_next = res_status;
    res_char_next   = res_char;
    rsp_valid_next  = rsp_valid && rsp_stall;
    rsp_status_next = rsp_status;
    rsp_cursor_next = rsp_cursor;
    rsp_length_next = rsp_length;
    rsp_char_next   = rsp_char;
    wr_en           = 1'b0;
    wr_addr         = pend_addr;
    wr_data         = rd_data;
    rd_en           = 1'b0;
    rd_addr         = phys[AW-1:0];

    unique case (state)
      S_IDLE: begin
        if (req_xfer) begin
          cmd_q_next      = cmd_t'(cmd);
          char_q_next     = char_in;
          res_status_next = ST_OK;
          res_char_next   = 8'd0;
          unique case (cmd_t'(cmd))
            CMD_INSERT: begin
              if (text_len == CAP_P) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else begin
                state_next = gap_at_cursor ? S_EXEC : S_MOVE;
              end
            end
            CMD_DELETE: begin
              if (cursor == '0) begin
                res_status_next = ST_NO_DELETE;
                state_next      = S_DONE;
              end else begin
                state_next = gap_at_cursor ? S_EXEC : S_MOVE;
              end
            end
            CMD_MOVE: begin
              if (target_bad) begin
                res_status_next = ST_BAD_MOVE;
              end else begin
                cursor_next = target[PW-1:0];
              end
              state_next = S_DONE;
            end
            CMD_READ: begin
              if (read_bad) begin
                res_status_next = ST_READ_RANGE;
                state_next      = S_DONE;
              end else begin
                rd_en      = 1'b1;
                state_next = S_RDWAIT;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // Walk the gap one byte per cycle: read the byte on the far side of the gap
      // and write the byte read in the cycle before to the opposite edge.
      S_MOVE: begin
        wr_en   = pend;
        wr_addr = pend_addr;
        wr_data = rd_data;
        if (!gap_at_cursor) begin
          rd_en     = 1'b1;
          pend_next = 1'b1;
          if (move_left) begin
            rd_addr        = gf_dec[AW-1:0];
            pend_addr_next = ge_dec[AW-1:0];
            gap_first_next = gf_dec;
            gap_end_next   = ge_dec;
          end else begin
            rd_addr        = gap_end[AW-1:0];
            pend_addr_next = gap_first[AW-1:0];
            gap_first_next = gf_inc;
            gap_end_next   = ge_inc;
          end
        end else begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (cmd_q == CMD_INSERT) begin
          wr_en          = 1'b1;
          wr_addr        = gap_first[AW-1:0];
          wr_data        = char_q;
          gap_first_next = gf_inc;
          cursor_next    = cursor + 1'b1;
        end else begin
          gap_first_next = gf_dec;
          cursor_next    = cursor - 1'b1;
        end
        state_next = S_DONE;
      end

      S_RDWAIT: begin
        res_char_next = rd_data;
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (rsp_free) begin
          rsp_valid_next  = 1'b1;
          rsp_status_next = res_status;
          rsp_cursor_next = cursor_w[10:0];
          rsp_length_next = length_w[10:0];
          rsp_char_next   = res_char;
          state_next      = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      gap_first <= '0;
      gap_end   <= CAP_P;
      cursor    <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      gap_first <= gap_first_next;
      gap_end   <= gap_end_next;
      cursor    <= cursor_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr  <= pend_addr_next;
    cmd_q      <= cmd_q_next;
    char_q     <= char_q_next;
    res_status <= res_status_next;
    res_char   <= res_char_next;
    rsp_status <= rsp_status_next;
    rsp_cursor <= rsp_cursor_next;
    rsp_length <= rsp_length_next;
    rsp_char   <= rsp_char_next;
  end

  // The walk never reads and writes one address in the same cycle, so the
  // store needs no forwarding.
  gbte_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign status      = rsp_status;
  assign cursor_pos  = rsp_cursor;
  assign text_length = rsp_length;
  assign char_out    = rsp_char;

`ifndef NO_ASSERTIONS
  a_gap_order: assert property (@(posedge clk) disable iff (rst)
    gap_end >= gap_first)
    else $error("gap end fell below gap start");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= text_len)
    else $error("cursor beyond end of text");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("byte store read and write hit one address");

  a_exec_at_gap: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> gap_at_cursor)
    else $error("edit executed with gap away from cursor");
`endif

endmodule

// ===== tb/gap_buffer_edit_checker.sv =====
// Checker for the gap buffer editor: mirrors the text store and compares every result.
`timescale 1ns / 100ps

module gap_buffer_edit_checker
  import gbte_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  logic               req_stall,
  input  logic [1:0]         cmd,
  input  logic [7:0]         char_in,
  input  logic signed [11:0] move_amount,
  input  logic [9:0]         read_pos,
  input  logic               rsp_valid,
  input  logic               rsp_stall,
  input  logic [2:0]         status,
  input  logic [10:0]        cursor_pos,
  input  logic [10:0]        text_length,
  input  logic [7:0]         char_out,
  output int                 mismatches,
  output int                 outstanding,
  output logic [10:0]        cursor_now,
  output logic [10:0]        length_now
);

  typedef struct packed {
    status_t     status;
    logic [10:0] cursor;
    logic [10:0] length;
    logic [7:0]  ch;
  } edit_result_t;

  // Mirror of the text: bytes, gap bounds and the logical cursor.
  logic [7:0] store [CAPACITY];
  int gap_lo;
  int gap_hi;
  int caret;

  edit_result_t expected_results[$];
  edit_result_t want;
  edit_result_t got;

  function automatic int text_size();
    return CAPACITY - (gap_hi - gap_lo);
  endfunction

  // Slide the gap until it starts at the cursor.
  task automatic gap_to_caret();
    int gap_len;
    int n;
    gap_len = gap_hi - gap_lo;
    if (caret < gap_lo) begin
      for (int i = gap_lo - 1; i >= caret; i--) store[i + gap_len] = store[i];
      gap_lo = caret;
      gap_hi = caret + gap_len;
    end else if (caret > gap_lo) begin
      n = caret - gap_lo;
      for (int i = 0; i < n; i++) store[gap_lo + i] = store[gap_hi + i];
      gap_lo += n;
      gap_hi += n;
    end
  endtask

  task automatic apply_edit(input cmd_t c, input logic [7:0] ch,
                            input logic signed [11:0] amt, input logic [9:0] pos,
                            output edit_result_t res);
    int target;
    int phys;
    res.status = ST_OK;
    res.ch = 8'd0;
    case (c)
      CMD_INSERT: begin
        if (text_size() >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          gap_to_caret();
          store[gap_lo] = ch;
          gap_lo++;
          caret++;
        end
      end
      CMD_DELETE: begin
        if (caret == 0) begin
          res.status = ST_NO_DELETE;
        end else begin
          gap_to_caret();
          gap_lo--;
          caret--;
        end
      end
      CMD_MOVE: begin
        target = caret + int'(amt);
        if (target < 0 || target > text_size()) res.status = ST_BAD_MOVE;
        else caret = target;
      end
      default: begin
        if (int'(pos) >= text_size()) begin
          res.status = ST_READ_RANGE;
        end else begin
          phys = (int'(pos) < gap_lo) ? int'(pos) : int'(pos) + gap_hi - gap_lo;
          res.ch = store[phys];
        end
      end
    endcase
    res.cursor = 11'(caret);
    res.length = 11'(text_size());
  endtask

  task automatic check_field(input string field, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", field, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      gap_lo = 0;
      gap_hi = CAPACITY;
      caret = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      // Results are retired before the new command is added, so a stray result
      // can never be matched against a command taken on the same edge.
      if (rsp_valid && !rsp_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", int'(want.status), int'(status));
          check_field("cursor_pos", int'(want.cursor), int'(cursor_pos));
          check_field("text_length", int'(want.length), int'(text_length));
          check_field("char_out", int'(want.ch), int'(char_out));
        end
      end
      if (req_valid && !req_stall) begin
        apply_edit(cmd_t'(cmd), char_in, move_amount, read_pos, got);
        expected_results.push_back(got);
      end
    end
    outstanding <= expected_results.size();
    cursor_now <= 11'(caret);
    length_now <= 11'(text_size());
  end

endmodule

// ===== tb/gap_buffer_text_editor_tb.sv =====
// Testbench top for the gap buffer editor: stimulus, back pressure and verdict.
`timescale 1ns / 100ps

module gap_buffer_text_editor_tb
  import gbte_pkg::*;
();

  localparam int CAPACITY = 1024;
  // The slowest correct gap walk crosses the whole store; allow for the longest
  // sender gap and receiver stall on top of it, then take that several times over.
  localparam int WATCHDOG_LIMIT = 4 * (CAPACITY + 4 + 2 * 15);

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  logic [1:0]         cmd = CMD_READ;
  logic [7:0]         char_in = 8'd0;
  logic signed [11:0] move_amount = 12'sd0;
  logic [9:0]         read_pos = 10'd0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  logic [2:0]         status;
  logic [10:0]        cursor_pos;
  logic [10:0]        text_length;
  logic [7:0]         char_out;

  int          mismatches;
  int          outstanding;
  logic [10:0] cursor_now;
  logic [10:0] length_now;

  // Percent chance that a burst of idling starts, per side.
  int tx_idle_pct = 30;
  int rx_idle_pct = 30;
  int quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  gap_buffer_text_editor #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .char_in    (char_in),
    .move_amount(move_amount),
    .read_pos   (read_pos),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cursor_pos (cursor_pos),
    .text_length(text_length),
    .char_out   (char_out)
  );

  gap_buffer_edit_checker #(
    .CAPACITY(CAPACITY)
  ) i_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .cmd        (cmd),
    .char_in    (char_in),
    .move_amount(move_amount),
    .read_pos   (read_pos),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .status     (status),
    .cursor_pos (cursor_pos),
    .text_length(text_length),
    .char_out   (char_out),
    .mismatches (mismatches),
    .outstanding(outstanding),
    .cursor_now (cursor_now),
    .length_now (length_now)
  );

  // The receiver alternates between short runs of readiness and stall bursts of
  // random length. With rx_idle_pct at zero it never stalls.
  initial begin
    forever begin
      @(posedge clk);
      if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end
    end
  end

  // The watchdog counts cycles in which neither channel completes a transfer.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // Offer one command and hold it until the block takes it. An idle burst may
  // come first; valid stays high between back-to-back commands.
  task automatic send_edit(input cmd_t c, input logic [7:0] ch,
                           input logic signed [11:0] amt, input logic [9:0] pos);
    int idle_len;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      idle_len = $urandom_range(1, 15);
      req_valid <= 1'b0;
      repeat (idle_len) @(posedge clk);
    end
    req_valid   <= 1'b1;
    cmd         <= c;
    char_in     <= ch;
    move_amount <= amt;
    read_pos    <= pos;
    do @(posedge clk); while (req_stall);
  endtask

  // Shorthand for a move with random noise on the fields the block ignores.
  task automatic send_move(input int amt);
    send_edit(CMD_MOVE, 8'($urandom), 12'(amt), 10'($urandom));
  endtask

  task automatic send_read(input int pos);
    send_edit(CMD_READ, 8'($urandom), 12'($urandom), 10'(pos));
  endtask

  // One editing command shaped like real use. Typing dominates while the text is
  // short and deletes take over once it grows, which keeps gap walks moderate.
  // Most moves land inside the text, many of them near the cursor, and most reads
  // hit a held character; the rest carry raw field values. The cursor and length
  // come from the checker's mirror and may lag by the command just taken.
  task automatic send_random_edit();
    int   r;
    int   len;
    int   cur;
    int   target;
    cmd_t c;
    logic signed [11:0] amt;
    logic [9:0] pos;
    len = int'(length_now);
    cur = int'(cursor_now);
    r = $urandom_range(0, 99);
    amt = 12'($urandom);
    pos = 10'($urandom);
    if (r < ((len < 150) ? 45 : 25)) c = CMD_INSERT;
    else if (r < ((len < 150) ? 60 : 55)) c = CMD_DELETE;
    else if (r < 78) c = CMD_MOVE;
    else c = CMD_READ;
    if (c == CMD_MOVE && $urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 1) == 1) target = cur + int'($urandom_range(0, 8)) - 4;
      else target = int'($urandom_range(0, len));
      amt = 12'(target - cur);
    end
    if (c == CMD_READ && len > 0 && $urandom_range(0, 9) < 8) begin
      pos = 10'($urandom_range(0, len - 1));
    end
    send_edit(c, 8'($urandom), amt, pos);
  endtask

  // Hold the sender off until every expected result has come back.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  initial begin
    int len;
    int cur;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, starting from an empty text: rejected commands on the empty
    // buffer, the byte extremes, reads at both ends, a gap walk back to the start,
    // and move amounts at the limits of the signed field.
    send_edit(CMD_DELETE, 8'($urandom), 12'($urandom), 10'($urandom));
    send_read(0);
    send_read(1023);
    send_move(1);
    send_move(-1);
    send_move(0);
    send_edit(CMD_INSERT, 8'h00, 12'($urandom), 10'($urandom));
    send_edit(CMD_INSERT, 8'hFF, 12'($urandom), 10'($urandom));
    send_edit(CMD_INSERT, 8'h5A, 12'($urandom), 10'($urandom));
    send_read(0);
    send_read(2);
    send_read(3);
    send_move(-3);
    send_move(-1);
    send_edit(CMD_INSERT, 8'hA5, 12'($urandom), 10'($urandom));
    send_read(0);
    send_move(3);
    send_edit(CMD_DELETE, 8'($urandom), 12'($urandom), 10'($urandom));
    send_move(2047);
    send_move(-2048);
    send_move(1024);
    send_move(-1024);
    send_move(-2);
    send_edit(CMD_DELETE, 8'($urandom), 12'($urandom), 10'($urandom));
    send_read(1);

    // Random editing in segments, each with its own amount of idling per side.
    for (int i = 0; i < 560; i++) begin
      if (i % 50 == 0) begin
        tx_idle_pct = pick_idle_pct();
        rx_idle_pct = pick_idle_pct();
      end
      send_random_edit();
    end

    // Let the block empty out so the mirror's length is exact, then put the
    // cursor at the end of the text.
    drain_results();
    tx_idle_pct = 5;
    rx_idle_pct = 5;
    len = int'(length_now);
    cur = int'(cursor_now);
    send_move(len - cur);

    // Edits around the ends of the text: a read of the last byte, moves past both
    // ends, a swing to the start with an insert that brings the gap to the start of the
    // text, a delete at the start, and a walk back to the end with a delete there.
    tx_idle_pct = 30;
    rx_idle_pct = 30;
    send_read(len - 1);
    send_move(-1024);
    send_move(1024);
    send_move(-len);
    send_edit(CMD_INSERT, 8'($urandom), 12'($urandom), 10'($urandom));
    send_move(-1);
    send_edit(CMD_DELETE, 8'($urandom), 12'($urandom), 10'($urandom));
    send_move(len + 1);
    send_edit(CMD_DELETE, 8'($urandom), 12'($urandom), 10'($urandom));
    send_read(0);
    send_read(len);
    send_move(2047);
    send_move(-2048);

    // The last stretch runs with both sides at full speed.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int i = 0; i < 50; i++) send_random_edit();

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== gap_buffer_text_editor.f =====
rtl/gbte_pkg.sv
rtl/gbte_ram.sv
rtl/gap_buffer_text_editor.sv
tb/gap_buffer_edit_checker.sv
tb/gap_buffer_text_editor_tb.sv
